[rtl/core/esw_pkg.sv]
// Shared types and constants for the single-wire dimming-command transmitter.
// Holds the register map, the reset values and the item and result structs.
// No dependencies.
`default_nettype none

package esw_pkg;

    localparam int ADDR_W        = 24;
    localparam int TICK_W        = 16;
    localparam int BRIGHT_W      = 9;
    localparam int CFG_IDX_W     = 3;
    localparam int BRIGHT_BITS   = 5;
    localparam int RFA_BIT_POS   = 7;
    localparam int ACK_POLL_STEP = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RFA_ENABLE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EOS_TICKS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_TICKS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_TICKS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_WINDOW_TICKS = 3'd7;

    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS   = 24'h007200;
    localparam logic [TICK_W-1:0] RST_START_TICKS      = 16'd4;
    localparam logic [TICK_W-1:0] RST_EOS_TICKS        = 16'd4;
    localparam logic [TICK_W-1:0] RST_ONE_LOW_TICKS    = 16'd3;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW_TICKS   = 16'd9;
    localparam logic [TICK_W-1:0] RST_ACK_WINDOW_TICKS = 16'd512;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic              lsb_first;
        logic              rfa_enable;
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] eos_ticks;
        logic [TICK_W-1:0] one_low_ticks;
        logic [TICK_W-1:0] zero_low_ticks;
        logic [TICK_W-1:0] ack_window_ticks;
    } t_cfg;

    typedef struct packed {
        logic                mode;
        logic [BRIGHT_W-1:0] brightness;
        logic                line_in;
    } t_item;

    // Packed so that line_level sits in bit 0.
    typedef struct packed {
        logic no_ack;
        logic ack_seen;
        logic done_res;
        logic busy_res;
        logic line_driven;
        logic line_level;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/esw_cfg.sv]
// Configuration register bank of the single-wire transmitter.
// Written through a plain index/data port; uses esw_pkg.
`default_nettype none

module esw_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [esw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [esw_pkg::ADDR_W-1:0]     i_cfg_data,
    output esw_pkg::t_cfg                       o_cfg
);

    esw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address   <= esw_pkg::RST_DEVICE_ADDRESS;
            r_cfg.lsb_first        <= 1'b0;
            r_cfg.rfa_enable       <= 1'b0;
            r_cfg.start_ticks      <= esw_pkg::RST_START_TICKS;
            r_cfg.eos_ticks        <= esw_pkg::RST_EOS_TICKS;
            r_cfg.one_low_ticks    <= esw_pkg::RST_ONE_LOW_TICKS;
            r_cfg.zero_low_ticks   <= esw_pkg::RST_ZERO_LOW_TICKS;
            r_cfg.ack_window_ticks <= esw_pkg::RST_ACK_WINDOW_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                esw_pkg::REG_DEVICE_ADDRESS: begin
                    r_cfg.device_address <= i_cfg_data;
                end
                esw_pkg::REG_LSB_FIRST: begin
                    r_cfg.lsb_first <= i_cfg_data[0];
                end
                esw_pkg::REG_RFA_ENABLE: begin
                    r_cfg.rfa_enable <= i_cfg_data[0];
                end
                esw_pkg::REG_START_TICKS: begin
                    r_cfg.start_ticks <= i_cfg_data[esw_pkg::TICK_W-1:0];
                end
                esw_pkg::REG_EOS_TICKS: begin
                    r_cfg.eos_ticks <= i_cfg_data[esw_pkg::TICK_W-1:0];
                end
                esw_pkg::REG_ONE_LOW_TICKS: begin
                    r_cfg.one_low_ticks <= i_cfg_data[esw_pkg::TICK_W-1:0];
                end
                esw_pkg::REG_ZERO_LOW_TICKS: begin
                    r_cfg.zero_low_ticks <= i_cfg_data[esw_pkg::TICK_W-1:0];
                end
                esw_pkg::REG_ACK_WINDOW_TICKS: begin
                    r_cfg.ack_window_ticks <= i_cfg_data[esw_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/esw_seq.sv]
// Frame sequencer of the single-wire transmitter: phase, countdown, frame
// shift and acknowledge window, advanced once per transaction. Uses esw_pkg.
`default_nettype none

module esw_seq #(
    parameter int FRAME_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire esw_pkg::t_item i_item,
    input  wire esw_pkg::t_cfg  i_cfg,
    output esw_pkg::t_result    o_result
);

    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] GAP_COUNT  = CNT_W'(FRAME_BITS - 8);
    localparam logic [esw_pkg::TICK_W-1:0] POLL_STEP =
        esw_pkg::TICK_W'(esw_pkg::ACK_POLL_STEP);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_GAP_LOW,
        PH_GAP_HIGH,
        PH_END_LOW,
        PH_ACK_POLL,
        PH_ACK_HOLD
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [esw_pkg::TICK_W-1:0]   r_countdown, n_countdown;
    logic [FRAME_BITS-1:0]        r_frame, n_frame;
    logic [CNT_W-1:0]             r_bits_left, n_bits_left;
    logic [esw_pkg::TICK_W-1:0]   r_ack_remaining, n_ack_remaining;
    logic                         r_drive_level, n_drive_level;
    logic                         r_order_lsb, n_order_lsb;
    logic                         r_rfa, n_rfa;

    logic                         done, ack, nack, released;
    logic [esw_pkg::TICK_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]             left_dec;
    logic                         bit_now, bit_next;
    logic [esw_pkg::ADDR_W-1:0]   frame_word;

    function automatic logic [esw_pkg::TICK_W-1:0] f_dur(
        input logic [esw_pkg::TICK_W-1:0] ticks
    );
        return (ticks == '0) ? esw_pkg::TICK_W'(1) : ticks;
    endfunction

    function automatic logic f_bit(
        input logic [FRAME_BITS-1:0] frame,
        input logic [CNT_W-1:0]      left,
        input logic                  lsb
    );
        logic [CNT_W-1:0] idx;
        idx = lsb ? (FULL_COUNT - left) : (left - CNT_W'(1));
        return frame[idx[IDX_W-1:0]];
    endfunction

    always_comb begin
        n_phase         = r_phase;
        n_countdown     = r_countdown;
        n_frame         = r_frame;
        n_bits_left     = r_bits_left;
        n_ack_remaining = r_ack_remaining;
        n_drive_level   = r_drive_level;
        n_order_lsb     = r_order_lsb;
        n_rfa           = r_rfa;
        done            = 1'b0;
        ack             = 1'b0;
        nack            = 1'b0;

        cnt_dec  = r_countdown - esw_pkg::TICK_W'(1);
        left_dec = r_bits_left - CNT_W'(1);
        bit_now  = f_bit(r_frame, r_bits_left, r_order_lsb);
        bit_next = f_bit(r_frame, left_dec, r_order_lsb);

        frame_word = i_cfg.device_address
                   | esw_pkg::ADDR_W'(i_item.brightness[esw_pkg::BRIGHT_BITS-1:0])
                   | (esw_pkg::ADDR_W'(i_cfg.rfa_enable) << esw_pkg::RFA_BIT_POS);

        if (i_item.mode) begin
            if (r_phase == PH_IDLE) begin
                n_frame         = frame_word[FRAME_BITS-1:0];
                n_order_lsb     = i_cfg.lsb_first;
                n_rfa           = i_cfg.rfa_enable;
                n_bits_left     = FULL_COUNT;
                n_ack_remaining = '0;
                n_phase         = PH_START;
                n_countdown     = f_dur(i_cfg.start_ticks);
                n_drive_level   = 1'b1;
            end
        end else if (r_phase == PH_ACK_POLL) begin
            if (!i_item.line_in) begin
                ack           = 1'b1;
                n_phase       = PH_ACK_HOLD;
                n_countdown   = f_dur(r_ack_remaining);
                n_drive_level = 1'b1;
            end else if (r_ack_remaining <= POLL_STEP) begin
                n_ack_remaining = '0;
                nack            = 1'b1;
                done            = 1'b1;
                n_phase         = PH_IDLE;
                n_countdown     = '0;
                n_drive_level   = 1'b1;
            end else begin
                n_ack_remaining = r_ack_remaining - POLL_STEP;
            end
        end else if (r_phase != PH_IDLE) begin
            n_countdown = cnt_dec;
            if (cnt_dec == '0) begin
                case (r_phase)
                    PH_START, PH_GAP_HIGH: begin
                        n_phase       = PH_BIT_LOW;
                        n_countdown   = f_dur(bit_now ? i_cfg.one_low_ticks
                                                      : i_cfg.zero_low_ticks);
                        n_drive_level = 1'b0;
                    end
                    PH_BIT_LOW: begin
                        n_phase       = PH_BIT_HIGH;
                        n_countdown   = f_dur(bit_now ? i_cfg.zero_low_ticks
                                                      : i_cfg.one_low_ticks);
                        n_drive_level = 1'b1;
                    end
                    PH_BIT_HIGH: begin
                        n_bits_left = left_dec;
                        if (!r_order_lsb && left_dec == GAP_COUNT) begin
                            n_phase       = PH_GAP_LOW;
                            n_countdown   = f_dur(i_cfg.eos_ticks);
                            n_drive_level = 1'b0;
                        end else if (left_dec == '0) begin
                            n_phase       = PH_END_LOW;
                            n_countdown   = f_dur(i_cfg.eos_ticks);
                            n_drive_level = 1'b0;
                        end else begin
                            n_phase       = PH_BIT_LOW;
                            n_countdown   = f_dur(bit_next ? i_cfg.one_low_ticks
                                                           : i_cfg.zero_low_ticks);
                            n_drive_level = 1'b0;
                        end
                    end
                    PH_GAP_LOW: begin
                        n_phase       = PH_GAP_HIGH;
                        n_countdown   = f_dur(i_cfg.start_ticks);
                        n_drive_level = 1'b1;
                    end
                    PH_END_LOW: begin
                        n_countdown   = '0;
                        n_drive_level = 1'b1;
                        if (!r_rfa) begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (i_cfg.ack_window_ticks == '0) begin
                            nack    = 1'b1;
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_ack_remaining = i_cfg.ack_window_ticks;
                            n_phase         = PH_ACK_POLL;
                        end
                    end
                    default: begin
                        done          = 1'b1;
                        n_phase       = PH_IDLE;
                        n_countdown   = '0;
                        n_drive_level = 1'b1;
                    end
                endcase
            end
        end

        released             = (n_phase == PH_ACK_POLL) || (n_phase == PH_ACK_HOLD);
        o_result.line_level  = released ? 1'b1 : n_drive_level;
        o_result.line_driven = !released;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.ack_seen    = ack;
        o_result.no_ack      = nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_countdown     <= '0;
            r_bits_left     <= '0;
            r_ack_remaining <= '0;
            r_drive_level   <= 1'b1;
            r_order_lsb     <= 1'b0;
            r_rfa           <= 1'b0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_countdown     <= n_countdown;
            r_bits_left     <= n_bits_left;
            r_ack_remaining <= n_ack_remaining;
            r_drive_level   <= n_drive_level;
            r_order_lsb     <= n_order_lsb;
            r_rfa           <= n_rfa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_frame <= n_frame;
        end
    end

endmodule

`default_nettype wire

[rtl/core/easyscale_single_wire_transmitter.sv]
// Top level of the single-wire dimming-command transmitter.
// Input register, frame sequencer and result register; uses esw_pkg,
// esw_cfg and esw_seq.
//
//   Channel   Direction  Handshake            Payload
//   s_axis    in         tvalid/tready        tuser: mode; tdata: brightness, line_in
//   m_axis    out        tvalid/tready        tdata: line_level .. no_ack
//   cfg       in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each transaction passes through the input register, then through the
// sequencer into the result register.
// A new transaction is accepted every cycle unless m_axis stalls; the state
// update of one tick feeds the next, so the sequencer step sets the clock rate.
// Reset is synchronous: the line is driven high and the block is idle.
// A stalled result holds the input register, which then stalls s_axis.
`default_nettype none

module easyscale_single_wire_transmitter #(
    parameter int FRAME_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // tdata: [8:0] brightness, [9] line_in, [15:10] zero
    input  wire logic [15:0]                   s_axis_tdata,
    // tuser: [0] mode
    input  wire logic                          s_axis_tuser,
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: [0] line_level, [1] line_driven, [2] busy_res, [3] done_res,
    //        [4] ack_seen, [5] no_ack, [7:6] zero
    output      logic [7:0]                    m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [esw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [esw_pkg::ADDR_W-1:0]    i_cfg_data
);

    esw_pkg::t_cfg    cfg;
    esw_pkg::t_result step_result;
    esw_pkg::t_item   r_in_item;
    esw_pkg::t_result r_out_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    esw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    esw_seq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.mode       <= s_axis_tuser;
            r_in_item.brightness <= s_axis_tdata[esw_pkg::BRIGHT_W-1:0];
            r_in_item.line_in    <= s_axis_tdata[esw_pkg::BRIGHT_W];
        end
        if (advance) begin
            r_out_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_result};

endmodule

`default_nettype wire

[rtl/core/esw_checker.sv]
// Port-level checker for the single-wire transmitter and its bind statement.
// Sees only the result channel of the top level; no package dependency.
`default_nettype none

module esw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic shown;

    assign shown = m_axis_tvalid && m_axis_tready;

    // A finished sequence leaves the block idle with the line driven high.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shown && m_axis_tdata[3] |-> !m_axis_tdata[2] && m_axis_tdata[1]
                                     && m_axis_tdata[0])
        else $error("done pulse while still busy or line not high");

    // Acknowledge and timeout never come together, and a timeout ends the frame.
    a_ack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shown && m_axis_tdata[5] |-> !m_axis_tdata[4] && m_axis_tdata[3])
        else $error("no_ack without done or together with ack_seen");

    // A released line only happens inside a busy sequence and reads high.
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shown && !m_axis_tdata[1] |-> m_axis_tdata[2] && m_axis_tdata[0])
        else $error("line released outside a sequence");

    // An acknowledge sample leaves the line released for the hold time.
    a_ack_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shown && m_axis_tdata[4] |-> !m_axis_tdata[1] && m_axis_tdata[2])
        else $error("ack_seen with the line driven");

endmodule

bind easyscale_single_wire_transmitter esw_checker u_esw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
